[hw/rtl/hsv_to_rgb_pixel_converter_assert.svh]
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion shorthands on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_ASSERT_SVH

// same-cycle implication
`define H2R_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/h2r_pkg.sv]
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, hue sector codes and the exact divide-by-255 helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DATA_W = 3 * PIX_W;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

  // floor(x / 255) for x below 65792: x = 255*hi + (hi + lo)
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [8:0] th;
    logic [9:0] u;
    logic [8:0] c;
    th = x[16:8];
    u  = {1'b0, th} + {2'b00, x[7:0]};
    if (u >= 10'd510) begin
      c = 9'd2;
    end else if (u >= 10'd255) begin
      c = 9'd1;
    end else begin
      c = 9'd0;
    end
    return th + c;
  endfunction

endpackage

[hw/rtl/hsv_to_rgb_pixel_converter.sv]
// ---------------------------------------------------------------------------
// HSV to RGB pixel converter
// Five-stage pipeline turning one 8-bit HSV pixel into one 8-bit RGB pixel.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one HSV pixel per request, tdata = {brightness,
//   saturation, hue}. Output stream m_*: one RGB pixel per request,
//   tdata = {blue, green, red}. Every input request yields exactly one
//   output request, in order.
//   Path: a request accepted on s_* passes five register stages (sector
//   split, two 8x8 products, 8x16 product, first and second divide by
//   255 with the channel select) before it is offered on m_*; a stall on
//   m_* can hold it in any stage.
//   Throughput: one pixel per clock when not stalled; each stage holds one pixel.
//   Stall: when m_tready_i is low, stages fill up from the output end;
//   s_tready_o drops only when all five stages hold a pixel.
//   Reset: all stages empty, m_tvalid_o low; data registers not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_converter
  import h2r_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // hue, saturation, brightness
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o    // red, green, blue
);

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && s_tvalid_i;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && vld_q[k-1];
    end
    vld_d[0] = rdy[0] ? s_tvalid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_tready_o = rdy[0];
  assign m_tvalid_o = vld_q[NSTG-1];

  // stage 1: hue sector and fraction
  logic [PIX_W-1:0] hue, sat_in, val_in;
  logic [10:0]      six_h, base, diff;
  logic [PIX_W-1:0] frac;
  sector_e          sec_d;
  logic [PIX_W-1:0] g_d;

  assign hue    = s_tdata_i[PIX_W-1:0];
  assign sat_in = s_tdata_i[2*PIX_W-1:PIX_W];
  assign val_in = s_tdata_i[3*PIX_W-1:2*PIX_W];
  assign six_h  = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  always_comb begin
    if (six_h >= 11'd1530) begin
      sec_d = SEC_0;
      base  = 11'd1530;
    end else if (six_h >= 11'd1275) begin
      sec_d = SEC_5;
      base  = 11'd1275;
    end else if (six_h >= 11'd1020) begin
      sec_d = SEC_4;
      base  = 11'd1020;
    end else if (six_h >= 11'd765) begin
      sec_d = SEC_3;
      base  = 11'd765;
    end else if (six_h >= 11'd510) begin
      sec_d = SEC_2;
      base  = 11'd510;
    end else if (six_h >= 11'd255) begin
      sec_d = SEC_1;
      base  = 11'd255;
    end else begin
      sec_d = SEC_0;
      base  = 11'd0;
    end
    diff = six_h - base;
    frac = diff[PIX_W-1:0];
    g_d  = (sec_d == SEC_1 || sec_d == SEC_3 || sec_d == SEC_5) ? ~frac : frac;
  end

  sector_e          sec1_q;
  logic [PIX_W-1:0] g1_q, s1_q, v1_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sec1_q <= sec_d;
      g1_q   <= g_d;
      s1_q   <= sat_in;
      v1_q   <= val_in;
    end
  end

  // stage 2: s*(255-g) and v*(255-s)
  logic [15:0] w_d, p_d;
  assign w_d = {8'b0, s1_q} * {8'b0, ~g1_q};
  assign p_d = {8'b0, v1_q} * {8'b0, ~s1_q};

  sector_e          sec2_q;
  logic [15:0]      w2_q, p2_q;
  logic [PIX_W-1:0] v2_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sec2_q <= sec1_q;
      w2_q   <= w_d;
      p2_q   <= p_d;
      v2_q   <= v1_q;
    end
  end

  // stage 3: v*(65025-w) and low level
  logic [15:0] dif_d;
  logic [23:0] y_d;
  logic [8:0]  low9;
  assign dif_d = 16'd65025 - w2_q;
  assign y_d   = {16'b0, v2_q} * {8'b0, dif_d};
  assign low9  = div255({1'b0, p2_q});

  sector_e          sec3_q;
  logic [23:0]      y3_q;
  logic [PIX_W-1:0] low3_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      sec3_q <= sec2_q;
      y3_q   <= y_d;
      low3_q <= low9[PIX_W-1:0];
      v3_q   <= v2_q;
    end
  end

  // stage 4: first divide by 255, using 65536 = 255*257 + 1
  logic [16:0] fold, hi257, q1full;
  logic [8:0]  qlo;
  assign fold   = {9'b0, y3_q[23:16]} + {1'b0, y3_q[15:0]};
  assign hi257  = {1'b0, y3_q[23:16], 8'b0} + {9'b0, y3_q[23:16]};
  assign qlo    = div255(fold);
  assign q1full = hi257 + {8'b0, qlo};

  sector_e          sec4_q;
  logic [15:0]      q4_q;
  logic [PIX_W-1:0] low4_q, v4_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      sec4_q <= sec3_q;
      q4_q   <= q1full[15:0];
      low4_q <= low3_q;
      v4_q   <= v3_q;
    end
  end

  // stage 5: second divide by 255 and channel select
  logic [8:0]       mid9;
  logic [PIX_W-1:0] mid, r_d, gr_d, b_d;
  assign mid9 = div255({1'b0, q4_q});
  assign mid  = mid9[PIX_W-1:0];

  always_comb begin
    case (sec4_q)
      SEC_0: begin
        r_d = v4_q;   gr_d = mid;    b_d = low4_q;
      end
      SEC_1: begin
        r_d = mid;    gr_d = v4_q;   b_d = low4_q;
      end
      SEC_2: begin
        r_d = low4_q; gr_d = v4_q;   b_d = mid;
      end
      SEC_3: begin
        r_d = low4_q; gr_d = mid;    b_d = v4_q;
      end
      SEC_4: begin
        r_d = mid;    gr_d = low4_q; b_d = v4_q;
      end
      default: begin
        r_d = v4_q;   gr_d = low4_q; b_d = mid;
      end
    endcase
  end

  logic [DATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      out_q <= {b_d, gr_d, r_d};
    end
  end

  assign m_tdata_o = out_q;

endmodule

[hw/rtl/h2r_checker.sv]
// ---------------------------------------------------------------------------
// HSV to RGB converter port checker
// Watches the stream ports of the converter for flow and latency slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsv_to_rgb_pixel_converter_assert.svh"

module h2r_checker
  import h2r_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_tvalid_i,
  input logic              s_tready_o,
  input logic [DATA_W-1:0] s_tdata_i,
  input logic              m_tvalid_o,
  input logic              m_tready_i,
  input logic [DATA_W-1:0] m_tdata_o
);

  `H2R_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o), "stalled output changed")
  `H2R_ASSERT_SAME(a_ready_flow, m_tready_i, s_tready_o, "input stalled while output is taken")
  `H2R_ASSERT_SAME(a_full_stall, !s_tready_o, m_tvalid_o && !m_tready_i, "input stalled with free stage")
  `H2R_ASSERT_NEXT(a_latency, (s_tvalid_i && s_tready_o) ##1 m_tready_i ##1 m_tready_i ##1 m_tready_i ##1 m_tready_i, m_tvalid_o, "pixel missing after pipeline latency")

endmodule

bind hsv_to_rgb_pixel_converter h2r_checker u_h2r_checker (.*);
